[rtl/msa_pkg.sv]
// Shared types and constants for the max_subarray_stream block.
// Depends on nothing; imported by msa_scan and max_subarray_stream.
package msa_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_LENGTH_DEF   = 65536;

  // Fixed widths of the scan state and the result fields
  localparam int SUM_W     = 32;           // running sum, signed
  localparam int SUM_EXT_W = SUM_W + 1;    // one guard bit for the add
  localparam int BEST_W    = 31;           // best sum, unsigned
  localparam int IDX_W     = 16;           // reported positions

  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;
  localparam logic [SUM_W-1:0]  SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_NEG_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Result transaction, first field in the highest bits
  typedef struct packed {
    logic              too_long;
    logic              found;
    logic [IDX_W-1:0]  run_final;
    logic [IDX_W-1:0]  run_first;
    logic [BEST_W-1:0] best_sum;
  } msa_result_t;

  localparam int RES_W       = $bits(msa_result_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

[rtl/msa_scan.sv]
// Running-sum scan state and update logic for max_subarray_stream.
// Depends on msa_pkg; one item is consumed per cycle when item_valid is high.
module msa_scan #(
  parameter int SAMPLE_WIDTH = msa_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_LENGTH   = msa_pkg::MAX_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           item_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           last,
  output msa_pkg::msa_result_t           result
);
  import msa_pkg::*;

  localparam int POS_W = $clog2(MAX_LENGTH + 1);
  localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W + 1;

  logic signed [SUM_W-1:0]     running_r, running_nxt;
  logic        [BEST_W-1:0]    best_r, best_nxt;
  logic        [IDX_W-1:0]     cur_begin_r, cur_begin_nxt;
  logic        [IDX_W-1:0]     best_begin_r, best_begin_nxt;
  logic        [IDX_W-1:0]     best_finish_r, best_finish_nxt;
  logic        [POS_W-1:0]     position_r, position_nxt;
  logic                        overflow_r, overflow_nxt;

  logic        [CMP_W-1:0]     pos_ext;
  logic        [IDX_W-1:0]     idx;
  logic signed [SUM_EXT_W-1:0] sample_ext;
  logic signed [SUM_EXT_W-1:0] sum_raw;
  logic signed [SUM_W-1:0]     sum_sat;
  logic                        restart;
  logic                        better;

  // Element position, saturated to the reported width
  assign pos_ext = CMP_W'(position_r);
  assign idx     = (pos_ext > CMP_W'(IDX_MAX)) ? IDX_MAX : pos_ext[IDX_W-1:0];

  // Running sum: restart on a non-positive previous sum, then saturate
  assign restart    = (running_r <= 0);
  assign sample_ext = SUM_EXT_W'(sample);
  assign sum_raw    = restart ? sample_ext : (SUM_EXT_W'(running_r) + sample_ext);

  always_comb begin
    if (sum_raw[SUM_EXT_W-1] != sum_raw[SUM_W-1]) begin
      sum_sat = sum_raw[SUM_EXT_W-1] ? $signed(SUM_NEG_MIN) : $signed(SUM_POS_MAX);
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
  end

  // Strictly greater only, so the earliest run keeps a tie
  assign better = (sum_sat > $signed({1'b0, best_r}));

  // Next state after this element
  always_comb begin
    running_nxt     = sum_sat;
    cur_begin_nxt   = restart ? idx : cur_begin_r;
    best_nxt        = best_r;
    best_begin_nxt  = best_begin_r;
    best_finish_nxt = best_finish_r;
    position_nxt    = position_r;
    overflow_nxt    = overflow_r;
    if (position_r >= POS_W'(MAX_LENGTH)) begin
      overflow_nxt = 1'b1;
    end else begin
      position_nxt = position_r + 1'b1;
    end
    if (better) begin
      best_nxt        = sum_sat[BEST_W-1:0];
      best_begin_nxt  = cur_begin_nxt;
      best_finish_nxt = idx;
    end
  end

  // Result as seen after the last element of a sequence
  always_comb begin
    result          = '0;
    result.too_long = overflow_nxt;
    if (best_nxt != '0) begin
      result.found     = 1'b1;
      result.best_sum  = best_nxt;
      result.run_first = best_begin_nxt;
      result.run_final = best_finish_nxt;
    end
  end

  // State registers; the last element clears them for the next sequence
  always_ff @(posedge clk) begin
    if (!rst_n || (item_valid && last)) begin
      running_r     <= '0;
      best_r        <= '0;
      cur_begin_r   <= '0;
      best_begin_r  <= '0;
      best_finish_r <= '0;
      position_r    <= '0;
      overflow_r    <= 1'b0;
    end else if (item_valid) begin
      running_r     <= running_nxt;
      best_r        <= best_nxt;
      cur_begin_r   <= cur_begin_nxt;
      best_begin_r  <= best_begin_nxt;
      best_finish_r <= best_finish_nxt;
      position_r    <= position_nxt;
      overflow_r    <= overflow_nxt;
    end
  end

endmodule

[rtl/max_subarray_stream.sv]
// Streaming maximum-subarray scan: one signed sample per transaction, tlast ends a sequence.
// A sequence's result passes the input register and then the result register before out_tvalid rises.
// Throughput: one sample per cycle; the running-sum feedback loop lies within msa_scan.
// Only a last sample waits, and only while the result register is still full.
// Reset (rst_n, synchronous, active low) empties both registers and clears the scan state.
// Depends on msa_pkg and msa_scan.
module max_subarray_stream #(
  parameter int SAMPLE_WIDTH = msa_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_LENGTH   = msa_pkg::MAX_LENGTH_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // Sample channel
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]            in_tdata,   // sample
  input  logic                                         in_tlast,
  // Result channel
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // best_sum[30:0], run_first[46:31], run_final[62:47], found[63], too_long[64]
  output logic [msa_pkg::OUT_TDATA_W-1:0]              out_tdata
);
  import msa_pkg::*;

  logic                           in_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] in_sample_r;
  logic                           in_last_r;
  logic                           out_valid_r;
  msa_result_t                    out_r;
  msa_result_t                    scan_result;
  logic                           out_free;
  logic                           advance;

  // Stage 1 moves on unless it holds a last sample and the result slot is busy
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_sample_r <= $signed(in_tdata[SAMPLE_WIDTH-1:0]);
      in_last_r   <= in_tlast;
    end
  end

  // Scan datapath
  msa_scan #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_LENGTH   (MAX_LENGTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .sample     (in_sample_r),
    .last       (in_last_r),
    .result     (scan_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_r <= scan_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r);

  // A result without a run carries zeros in the run fields
  a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |->
      (out_r.best_sum == '0 && out_r.run_first == '0 && out_r.run_final == '0))
    else $error("empty result carries nonzero run fields");

  // A found run is positive and does not end before it starts
  a_found_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.found) |->
      (out_r.best_sum != '0 && out_r.run_first <= out_r.run_final))
    else $error("found run has zero sum or reversed bounds");

  // Input stalls only behind a last sample waiting on a full result slot
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && in_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending result");

  // No result is shown right after reset
  a_reset_empty : assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid_r)
    else $error("result valid right after reset");

endmodule
